FILE: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge, reset excluded.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Implication whose consequent is checked in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

FILE: rtl/core/ddodo_pkg.sv
// ----------------------------------------------------------------------------
// ddodo_pkg
// Types, constants and tables for the differential-drive odometry block.
// ----------------------------------------------------------------------------
package ddodo_pkg;

   localparam int CordicStepsDefault = 16;
   localparam int CordicStepsMax     = 30;

   localparam logic signed [31:0] TenthDegQ32  = 32'sd7496132;
   localparam logic [31:0]        InvTwoPiQ32  = 32'd683565276;
   localparam logic signed [31:0] CordicGainQ30 = 32'sd652032874;

   localparam logic [1:0] CSR_WHEEL_RADIUS = 2'd0;
   localparam logic [1:0] CSR_INV_BASE     = 2'd1;
   localparam logic [1:0] CSR_PERIOD       = 2'd2;

   typedef struct packed {
      logic signed [31:0] right_position;
      logic signed [31:0] left_position;
      logic signed [15:0] right_rate;
      logic signed [15:0] left_rate;
   } req_type;

   typedef struct packed {
      logic signed [39:0] right_angle_rad;
      logic signed [39:0] left_angle_rad;
      logic signed [23:0] right_speed_rad;
      logic signed [23:0] left_speed_rad;
      logic signed [31:0] pose_x;
      logic signed [31:0] pose_y;
      logic [31:0]        heading;
   } rsp_type;

   // Multiplier request from the sequencer.
   typedef struct packed {
      logic signed [32:0] a;
      logic signed [32:0] b;
   } mul_op_type;

   function automatic logic [31:0] atan_turns(input logic [4:0] i);
      logic [31:0] r;
      begin
         case (i)
            5'd0:  r = 32'd536870912;
            5'd1:  r = 32'd316933406;
            5'd2:  r = 32'd167458907;
            5'd3:  r = 32'd85004756;
            5'd4:  r = 32'd42667331;
            5'd5:  r = 32'd21354465;
            5'd6:  r = 32'd10679838;
            5'd7:  r = 32'd5340245;
            5'd8:  r = 32'd2670163;
            5'd9:  r = 32'd1335087;
            5'd10: r = 32'd667544;
            5'd11: r = 32'd333772;
            5'd12: r = 32'd166886;
            5'd13: r = 32'd83443;
            5'd14: r = 32'd41722;
            5'd15: r = 32'd20861;
            5'd16: r = 32'd10430;
            5'd17: r = 32'd5215;
            5'd18: r = 32'd2608;
            5'd19: r = 32'd1304;
            5'd20: r = 32'd652;
            5'd21: r = 32'd326;
            5'd22: r = 32'd163;
            5'd23: r = 32'd81;
            5'd24: r = 32'd41;
            5'd25: r = 32'd20;
            5'd26: r = 32'd10;
            5'd27: r = 32'd5;
            5'd28: r = 32'd3;
            5'd29: r = 32'd1;
            default: r = 32'd0;
         endcase
         return r;
      end
   endfunction

endpackage

FILE: rtl/core/ddodo_mul.sv
// ----------------------------------------------------------------------------
// ddodo_mul
// Shared registered 33x33 signed multiplier.
// ----------------------------------------------------------------------------
module ddodo_mul (
   input  logic                  clock,
   input  ddodo_pkg::mul_op_type op,
   output logic signed [65:0]    product
);
   import ddodo_pkg::*;

   logic signed [65:0] product_ff;

   always_ff @(posedge clock) begin
      product_ff <= op.a * op.b;
   end

   assign product = product_ff;
endmodule

FILE: rtl/core/ddodo_cordic.sv
// ----------------------------------------------------------------------------
// ddodo_cordic
// Iterative CORDIC rotation: one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module ddodo_cordic #(
   parameter int CORDIC_STEPS = ddodo_pkg::CordicStepsDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [31:0]        angle,
   output logic               done,
   output logic signed [35:0] cos_val,
   output logic signed [35:0] sin_val
);
   import ddodo_pkg::*;

   localparam int Steps = (CORDIC_STEPS > CordicStepsMax) ? CordicStepsMax : CORDIC_STEPS;

   logic signed [35:0] x_ff, y_ff, x_in, y_in;
   logic signed [33:0] z_ff, z_in;
   logic [4:0]         i_ff, i_in;
   logic               busy_ff, busy_in, flip_ff, flip_in;
   logic signed [33:0] z0;
   logic signed [35:0] xs, ys;

   always_comb begin
      z0 = {{2{angle[31]}}, angle};
      flip_in = flip_ff;
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      i_in = i_ff;
      busy_in = busy_ff;
      xs = x_ff >>> i_ff;
      ys = y_ff >>> i_ff;
      if (start) begin
         flip_in = 1'b0;
         if (z0 > 34'sd1073741824) begin
            z0 = z0 - 34'sd2147483648;
            flip_in = 1'b1;
         end else if (z0 < -34'sd1073741824) begin
            z0 = z0 + 34'sd2147483648;
            flip_in = 1'b1;
         end
         x_in = 36'(CordicGainQ30);
         y_in = '0;
         z_in = z0;
         i_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (z_ff >= 0) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - $signed({2'b00, atan_turns(i_ff)});
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + $signed({2'b00, atan_turns(i_ff)});
         end
         i_in = i_ff + 5'd1;
         if (i_ff == 5'(Steps - 1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      i_ff <= i_in;
      flip_ff <= flip_in;
   end

   // High whenever no rotation is running; results hold until the next start.
   assign done = !busy_ff;
   assign cos_val = flip_ff ? -x_ff : x_ff;
   assign sin_val = flip_ff ? -y_ff : y_ff;
endmodule

FILE: rtl/core/diff_drive_odometry_unit.sv
// A request beat is taken only in the idle state, and the sequencer returns to idle
// once the response register loads, so the block holds one request at a time.
// A response still waiting in its register holds the sequencer in its load state.
// Reset is synchronous, active high: pose and heading clear to zero, registers
// return to radius 1311, inverse base 2560, period 655.
// ----------------------------------------------------------------------------
// diff_drive_odometry_unit
// Dead-reckoning pose integrator for a differential-drive base.
// ----------------------------------------------------------------------------
module diff_drive_odometry_unit #(
   parameter int CORDIC_STEPS = ddodo_pkg::CordicStepsDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  ddodo_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output ddodo_pkg::rsp_type rsp_data,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata
);
   import ddodo_pkg::*;
   `include "assert_macros.svh"

   // One multiplier product per issuing state; the product shows up in the following state.
   typedef enum logic [4:0] {
      S_IDLE, S_RP, S_LP, S_RR, S_LR, S_RT, S_RTCAP, S_DIST, S_TURN, S_TCAP,
      S_TBH, S_TBL, S_TMAG, S_TA, S_TB, S_HEAD, S_CWAIT, S_MX, S_MY, S_PY, S_OUT
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [15:0] radius_ff, invb_ff, period_ff;

   // Working registers.
   req_type            req_ff;
   logic signed [39:0] ra_ff, la_ff;
   logic signed [23:0] wr_ff, wl_ff;
   logic [31:0]        rt_ff;
   logic signed [32:0] dist_ff;
   logic signed [39:0] turn_ff;
   logic signed [36:0] tbh_ff;
   logic [55:0]        tmag_ff;
   logic               tneg_ff;
   logic [65:0]        tlo_ff;
   logic signed [31:0] acc_x_ff, acc_y_ff;
   logic [31:0]        acc_h_ff;
   rsp_type            rsp_ff;
   logic               rsp_valid_ff;

   mul_op_type         mop;
   logic signed [65:0] prod;
   logic               cstart, cdone;
   logic signed [35:0] cosv, sinv;
   logic               out_free;

   ddodo_mul u_mul (.clock(clock), .op(mop), .product(prod));

   ddodo_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock(clock), .reset(reset), .start(cstart), .angle(acc_h_ff),
      .done(cdone), .cos_val(cosv), .sin_val(sinv)
   );

   // Round half up of a product by s fraction bits (Q.16 for most callers): add half LSB, arithmetic shift.
   function automatic logic signed [65:0] rnd(input logic signed [65:0] v,
                                               input int s);
      logic signed [65:0] h;
      begin
         h = 66'sd1 <<< (s - 1);
         return (v + h) >>> s;
      end
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      begin
         if (v > 34'sd2147483647) return 32'sh7fffffff;
         if (v < -34'sd2147483648) return 32'sh80000000;
         return v[31:0];
      end
   endfunction

   // The response register is free when empty or when its beat leaves this cycle.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Select the multiplier operands for the current step.
   always_comb begin
      mop = '{a: '0, b: '0};
      case (state_ff)
         S_RP: mop = '{a: 33'(req_ff.right_position), b: 33'(TenthDegQ32)};
         S_LP: mop = '{a: 33'(req_ff.left_position),  b: 33'(TenthDegQ32)};
         S_RR: mop = '{a: 33'(req_ff.right_rate),     b: 33'(TenthDegQ32)};
         S_LR: mop = '{a: 33'(req_ff.left_rate),      b: 33'(TenthDegQ32)};
         // radius times period first, so each rate term needs a single product
         S_RT: mop = '{a: $signed({17'd0, radius_ff}), b: $signed({17'd0, period_ff})};
         S_DIST: mop = '{a: 33'(wr_ff) + 33'(wl_ff), b: $signed({1'b0, rt_ff})};
         S_TURN: mop = '{a: 33'(wr_ff) - 33'(wl_ff), b: $signed({1'b0, rt_ff})};
         // turn travel times inverse base, split into upper and lower 20 bits
         S_TBH: mop = '{a: 33'($signed(turn_ff[39:20])), b: $signed({17'd0, invb_ff})};
         S_TBL: mop = '{a: $signed({13'd0, turn_ff[19:0]}), b: $signed({17'd0, invb_ff})};
         S_TA: mop = '{a: $signed({1'b0, tmag_ff[31:0]}),
                       b: $signed({1'b0, InvTwoPiQ32})};
         S_TB: mop = '{a: $signed({9'd0, tmag_ff[55:32]}),
                       b: $signed({1'b0, InvTwoPiQ32})};
         S_MX: mop = '{a: dist_ff, b: 33'(cosv)};
         S_MY: mop = '{a: dist_ff, b: 33'(sinv)};
         default: mop = '{a: '0, b: '0};
      endcase
   end

   always_comb begin
      state_in = state_ff;
      cstart = 1'b0;
      case (state_ff)
         S_IDLE: if (req_valid) begin
            // take the beat and start rotating the heading held from the last step
            state_in = S_RP;
            cstart = 1'b1;
         end
         S_RP: state_in = S_LP;
         S_LP: state_in = S_RR;
         S_RR: state_in = S_LR;
         S_LR: state_in = S_RT;
         S_RT: state_in = S_RTCAP;
         S_RTCAP: state_in = S_DIST;
         S_DIST: state_in = S_TURN;
         S_TURN: state_in = S_TCAP;
         S_TCAP: state_in = S_TBH;
         S_TBH: state_in = S_TBL;
         S_TBL: state_in = S_TMAG;
         S_TMAG: state_in = S_TA;
         S_TA: state_in = S_TB;
         S_TB: state_in = S_HEAD;
         S_HEAD: state_in = S_CWAIT;
         // hold until the CORDIC has finished its rotations
         S_CWAIT: if (cdone) state_in = S_MX;
         S_MX: state_in = S_MY;
         S_MY: state_in = S_PY;
         S_PY: state_in = S_OUT;
         S_OUT: if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Turn in Q40 and its conversion to a binary angle, rounded on the magnitude.
   logic signed [56:0] turnib;
   logic [65:0]        res_next;
   always_comb begin
      turnib = (57'(tbh_ff) <<< 20) + 57'(prod);
      res_next = ($unsigned(prod) >> 8) + (((66'(prod[7:0]) << 32) + tlo_ff) >> 40);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         radius_ff <= 16'd1311;
         invb_ff <= 16'd2560;
         period_ff <= 16'd655;
         acc_x_ff <= '0;
         acc_y_ff <= '0;
         acc_h_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_OUT && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         if (csr_write) begin
            case (csr_index)
               CSR_WHEEL_RADIUS: radius_ff <= csr_wdata;
               CSR_INV_BASE:     invb_ff <= csr_wdata;
               CSR_PERIOD:       period_ff <= csr_wdata;
               default: ;
            endcase
         end
         case (state_ff)
            S_IDLE: if (req_valid) req_ff <= req_data;
            S_LP: ra_ff <= 40'(rnd(prod, 16));
            S_RR: la_ff <= 40'(rnd(prod, 16));
            S_LR: wr_ff <= 24'(rnd(prod, 16));
            S_RT: wl_ff <= 24'(rnd(prod, 16));
            S_RTCAP: rt_ff <= prod[31:0];
            // travel per step in Q24
            S_TURN: dist_ff <= 33'(rnd(prod, 25));
            // wheel travel difference in Q32, turned into radians by the inverse base
            S_TCAP: turn_ff <= 40'(rnd(prod, 16));
            S_TBL: tbh_ff <= 37'(prod);
            S_TMAG: begin
               tneg_ff <= turnib < 0;
               tmag_ff <= (turnib < 0) ? 56'(-turnib) : 56'(turnib);
            end
            S_TB: tlo_ff <= $unsigned(prod) + (66'd1 << 39);
            // advance the heading; wraps modulo one turn
            S_HEAD: begin
               acc_h_ff <= acc_h_ff + (tneg_ff ? 32'd0 - res_next[31:0] : res_next[31:0]);
            end
            S_MY: acc_x_ff <= sat32(34'(acc_x_ff) + 34'(rnd(prod, 38)));
            S_PY: acc_y_ff <= sat32(34'(acc_y_ff) + 34'(rnd(prod, 38)));
            S_OUT: if (out_free) begin
               rsp_ff.right_angle_rad <= ra_ff;
               rsp_ff.left_angle_rad <= la_ff;
               rsp_ff.right_speed_rad <= wr_ff;
               rsp_ff.left_speed_rad <= wl_ff;
               rsp_ff.pose_x <= acc_x_ff;
               rsp_ff.pose_y <= acc_y_ff;
               rsp_ff.heading <= acc_h_ff;
            end
            default: ;
         endcase
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   `ASSERT_IMPL(a_busy_stall, clock, reset, state_ff != S_IDLE, req_stall,
                "request taken while busy")
   `ASSERT_NEXT(a_out_valid, clock, reset, state_ff == S_OUT, rsp_valid_ff,
                "response not raised")
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid_ff && rsp_stall,
                rsp_valid_ff && $stable(rsp_ff), "stalled response beat changed")
endmodule
